### rtl/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared constants and the arctangent table of the arc pose step pipeline.
// ----------------------------------------------------------------------------
package apsp_pkg;

  // Phases are 32-bit binary angles (a full turn is 2^32)
  localparam int PH_W = 32;
  // CORDIC datapath width, signed Q30 with headroom
  localparam int CS_W = 34;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Multiplier slice width
  localparam int MUL_CHUNK = 32;

  // round(2^44 / (4 pi)) for the half arc angle
  localparam int HAG_W = 41;
  localparam logic [HAG_W-1:0] HALF_ARC_GAIN = 41'd1399941684381;

  // ceil(2^24 / 3), exact reciprocal for values below 2^23
  localparam int RCP_W = 23;
  localparam logic [RCP_W-1:0] RECIP3 = 23'd5592406;

  // One in Q30
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Arctangent of 2^-i in 32-bit phase units
  function automatic logic [PH_W-1:0] atan_turn(input logic [4:0] idx);
    logic [PH_W-1:0] a;
    case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/apsp_cordic.sv
// ----------------------------------------------------------------------------
// apsp_cordic
// Pipelined rotation CORDIC: phase in, Q30 cosine and sine out, one stage
// per step, with a side payload that travels alongside.
// ----------------------------------------------------------------------------
module apsp_cordic #(
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [apsp_pkg::PH_W-1:0]         in_phase,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic signed [apsp_pkg::CS_W-1:0]  out_cos,
  output logic signed [apsp_pkg::CS_W-1:0]  out_sin,
  output logic [SIDE_W-1:0]                 out_side
);
  import apsp_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic signed [CS_W-1:0] x_r [0:N];
  logic signed [CS_W-1:0] y_r [0:N];
  logic signed [CS_W-1:0] z_r [0:N];
  logic signed [CS_W-1:0] x_nxt [0:N-1];
  logic signed [CS_W-1:0] y_nxt [0:N-1];
  logic signed [CS_W-1:0] z_nxt [0:N-1];
  logic [N:0]             v_r;
  logic [N:0]             flip_r;
  logic [SIDE_W-1:0]      side_r [0:N];
  logic                   flip_in;
  logic [PH_W-1:0]        ph_in;
  logic                   ov_r;
  logic signed [CS_W-1:0] oc_r, os_r;
  logic [SIDE_W-1:0]      oside_r;

  // Fold the left half plane onto the right one
  always_comb begin
    flip_in = in_phase[PH_W-2] ^ in_phase[PH_W-1];
    ph_in   = flip_in ? {~in_phase[PH_W-1], in_phase[PH_W-2:0]} : in_phase;
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    always_comb begin
      if (!z_r[i][CS_W-1]) begin
        x_nxt[i] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i] = y_r[i] + (x_r[i] >>> i);
        z_nxt[i] = z_r[i] - $signed({{(CS_W-PH_W){1'b0}}, atan_turn(5'(i))});
      end else begin
        x_nxt[i] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i] = y_r[i] - (x_r[i] >>> i);
        z_nxt[i] = z_r[i] + $signed({{(CS_W-PH_W){1'b0}}, atan_turn(5'(i))});
      end
    end
  end

  // Advance every stage together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[N-1:0], in_valid};
      ov_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= CS_W'($signed(ph_in));
      flip_r[0] <= flip_in;
      side_r[0] <= in_side;
      for (int i = 0; i < N; i++) begin
        x_r[i+1]    <= x_nxt[i];
        y_r[i+1]    <= y_nxt[i];
        z_r[i+1]    <= z_nxt[i];
        flip_r[i+1] <= flip_r[i];
        side_r[i+1] <= side_r[i];
      end
      oc_r    <= flip_r[N] ? -x_r[N] : x_r[N];
      os_r    <= flip_r[N] ? -y_r[N] : y_r[N];
      oside_r <= side_r[N];
    end
  end

  assign out_valid = ov_r;
  assign out_cos   = oc_r;
  assign out_sin   = os_r;
  assign out_side  = oside_r;

endmodule

### rtl/apsp_div.sv
// ----------------------------------------------------------------------------
// apsp_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// side payload that travels alongside.
// ----------------------------------------------------------------------------
module apsp_div #(
  parameter int NW     = 8,
  parameter int DW     = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     in_num,
  input  logic [DW-1:0]     in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NW-1:0]     out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic [NW-1:0]     nq_r   [0:NW];
  logic [DW-1:0]     rem_r  [0:NW];
  logic [DW-1:0]     den_r  [0:NW];
  logic [SIDE_W-1:0] side_r [0:NW];
  logic [NW-1:0]     nq_nxt  [0:NW-1];
  logic [DW-1:0]     rem_nxt [0:NW-1];
  logic [NW:0]       v_r;

  // Shift in one numerator bit, subtract when it fits
  for (genvar i = 0; i < NW; i++) begin : g_bit
    logic [DW:0] trial;
    logic        ge;
    always_comb begin
      trial      = {rem_r[i], nq_r[i][NW-1]};
      ge         = trial >= {1'b0, den_r[i]};
      rem_nxt[i] = ge ? DW'(trial - {1'b0, den_r[i]}) : trial[DW-1:0];
      nq_nxt[i]  = {nq_r[i][NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq_r[0]   <= in_num;
      rem_r[0]  <= '0;
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int i = 0; i < NW; i++) begin
        nq_r[i+1]   <= nq_nxt[i];
        rem_r[i+1]  <= rem_nxt[i];
        den_r[i+1]  <= den_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = v_r[NW];
  assign out_quo   = nq_r[NW];
  assign out_side  = side_r[NW];

endmodule

### rtl/apsp_mul.sv
// ----------------------------------------------------------------------------
// apsp_mul
// Pipelined unsigned multiplier: one 32x32 partial product is added per
// stage, with a side payload that travels alongside.
// ----------------------------------------------------------------------------
module apsp_mul #(
  parameter int AW     = 32,
  parameter int BW     = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [AW-1:0]     in_a,
  input  logic [BW-1:0]     in_b,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [AW+BW-1:0]  out_prod,
  output logic [SIDE_W-1:0] out_side
);
  import apsp_pkg::*;

  localparam int NA   = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB   = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NP   = NA * NB;
  localparam int ACCW = (NA + NB) * MUL_CHUNK;

  logic [NA*MUL_CHUNK-1:0] a_r    [0:NP];
  logic [NB*MUL_CHUNK-1:0] b_r    [0:NP];
  logic [ACCW-1:0]         acc_r  [0:NP];
  logic [SIDE_W-1:0]       side_r [0:NP];
  logic [ACCW-1:0]         acc_nxt [0:NP-1];
  logic [NP:0]             v_r;

  // Add one shifted partial product per stage
  for (genvar j = 0; j < NP; j++) begin : g_pp
    localparam int IA = j % NA;
    localparam int IB = j / NA;
    logic [2*MUL_CHUNK-1:0] pp;
    always_comb begin
      pp = a_r[j][MUL_CHUNK*IA +: MUL_CHUNK] * b_r[j][MUL_CHUNK*IB +: MUL_CHUNK];
      acc_nxt[j] = acc_r[j] + (ACCW'(pp) << (MUL_CHUNK * (IA + IB)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NP-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]    <= (NA*MUL_CHUNK)'(in_a);
      b_r[0]    <= (NB*MUL_CHUNK)'(in_b);
      acc_r[0]  <= '0;
      side_r[0] <= in_side;
      for (int j = 0; j < NP; j++) begin
        a_r[j+1]    <= a_r[j];
        b_r[j+1]    <= b_r[j];
        acc_r[j+1]  <= acc_nxt[j];
        side_r[j+1] <= side_r[j];
      end
    end
  end

  assign out_valid = v_r[NP];
  assign out_prod  = acc_r[NP][AW+BW-1:0];
  assign out_side  = side_r[NP];

endmodule

### rtl/ackermann_arc_pose_step.sv
// ----------------------------------------------------------------------------
// ackermann_arc_pose_step
// Exact circular-arc pose step of a rear-axle bicycle model in fixed point.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | pos_x, pos_y, heading, arc_length,
//           |     |                      | steer_angle
//   out_    | out | out_tvalid/out_tready| next_x, next_y, next_heading
//   cfg_    | in  | cfg_wr_en            | wheelbase
//
// One item per cycle while the skid register is empty; the path runs through
// three 30-step CORDIC units and three one-bit-per-stage dividers.
// rst_n is synchronous and clears all valid bits and the wheelbase to 2.5 m.
// A stalled output parks one item in a skid register; the pipeline and
// in_tready hold only while that register is full.
// ----------------------------------------------------------------------------
module ackermann_arc_pose_step #(
  parameter int POSITION_WIDTH = 32,
  parameter int ANGLE_WIDTH    = 16
) (
  input  logic clk,
  input  logic rst_n,
  // pos_x, pos_y, heading, arc_length, steer_angle (low bits first)
  input  logic [((3*POSITION_WIDTH+2*ANGLE_WIDTH-1+7)/8)*8-1:0] in_tdata,
  input  logic in_tvalid,
  output logic in_tready,
  // next_x, next_y, next_heading (low bits first)
  output logic [((2*POSITION_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] out_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_wr_en,
  input  logic [30:0] cfg_wr_data
);
  import apsp_pkg::*;

  localparam int PW     = POSITION_WIDTH;
  localparam int AW     = ANGLE_WIDTH;
  localparam int PS     = PH_W - AW;
  localparam int OUT_W  = 2*PW + AW;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
  localparam int KW     = 54;            // curvature magnitude, Q32
  localparam int TW     = 36;            // tangent magnitude, Q30
  localparam int PPW    = KW + PW;       // |k|*|s|
  localparam int PGW    = PPW + HAG_W;   // |k|*|s|*gain
  localparam int HW     = 27;            // half arc in Q30 radians, small case
  localparam int UW     = 23;
  localparam int MW     = 31;
  localparam int CW     = CS_W - 1 + 19; // chord magnitude
  localparam int MXW    = CW + CS_W - 1;
  localparam int RW     = MXW - 30;
  localparam int MVW    = RW + 1;
  localparam int SUMW   = MVW + 1;
  localparam logic signed [AW-2:0] STEER_LIM = (AW-1)'((2**(AW-2)) * 125 / 128);
  localparam logic signed [SUMW-1:0] MAXP = {{(SUMW-PW+1){1'b0}}, {(PW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] MINP = ~MAXP;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] s;
    logic [PW-1:0]        sabs;
    logic [PH_W-1:0]      th;
    logic                 kneg;
    logic [KW-1:0]        kmag;
    logic                 pz;
    logic                 short_arc;
    logic [PH_W-1:0]      hph;
    logic [HW-1:0]        h27;
    logic [CW-1:0]        csm;
    logic                 cneg;
    logic [CW-1:0]        cmag;
    logic [AW-1:0]        nh;
    logic                 xneg;
    logic                 yneg;
  } pl_t;

  localparam int SW = $bits(pl_t);

  logic [30:0]     wheelbase_r;
  logic            en;
  logic            v0_r;
  pl_t             d0_r, d0_nxt;
  logic [PH_W-1:0] stp_r, stp_nxt;
  logic signed [AW-2:0] st_in, st_c;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheelbase_r <= 31'd163840;
    end else if (cfg_wr_en) begin
      wheelbase_r <= cfg_wr_data;
    end
  end

  // Unpack the item and clamp the steering angle
  always_comb begin
    d0_nxt      = '0;
    d0_nxt.x    = in_tdata[PW-1:0];
    d0_nxt.y    = in_tdata[2*PW-1:PW];
    d0_nxt.th   = {in_tdata[2*PW+AW-1:2*PW], {PS{1'b0}}};
    d0_nxt.s    = in_tdata[3*PW+AW-1:2*PW+AW];
    d0_nxt.sabs = d0_nxt.s[PW-1] ? PW'(-d0_nxt.s) : PW'(d0_nxt.s);
    st_in       = in_tdata[3*PW+2*AW-2:3*PW+AW];
    if (st_in > STEER_LIM) begin
      st_c = STEER_LIM;
    end else if (st_in < -STEER_LIM) begin
      st_c = -STEER_LIM;
    end else begin
      st_c = st_in;
    end
    stp_nxt = {st_c[AW-2], st_c, {PS{1'b0}}};
  end

  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_r  <= d0_nxt;
      stp_r <= stp_nxt;
    end
  end

  // Sine and cosine of the steering angle
  logic                   c1_v;
  logic signed [CS_W-1:0] c1_cos, c1_sin;
  logic [SW-1:0]          c1_sd;

  apsp_cordic #(.SIDE_W(SW)) u_cordic_steer (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v0_r), .in_phase(stp_r), .in_side(d0_r),
    .out_valid(c1_v), .out_cos(c1_cos), .out_sin(c1_sin), .out_side(c1_sd)
  );

  // tan = |sin| / cos, Q30
  pl_t               d1_in;
  logic [31:0]       den1;
  logic [CS_W-1:0]   ss_abs;
  logic [CS_W+28:0]  num1;

  always_comb begin
    d1_in      = pl_t'(c1_sd);
    d1_in.kneg = c1_sin[CS_W-1];
    den1       = (c1_cos < 1) ? 32'd1 : c1_cos[31:0];
    ss_abs     = c1_sin[CS_W-1] ? CS_W'(-c1_sin) : CS_W'(c1_sin);
    num1       = {ss_abs[CS_W-2:0], 30'b0};
  end

  logic            q1_v;
  logic [CS_W+28:0] q1;
  logic [SW-1:0]   q1_sd;

  apsp_div #(.NW(CS_W+29), .DW(32), .SIDE_W(SW)) u_div_tan (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(c1_v), .in_num(num1), .in_den(den1), .in_side(d1_in),
    .out_valid(q1_v), .out_quo(q1), .out_side(q1_sd)
  );

  // Curvature |k| = tan / wheelbase, Q32 per metre
  logic [30:0]         len;
  logic [TW+17:0]      num2;

  always_comb begin
    len  = (wheelbase_r == '0) ? 31'd1 : wheelbase_r;
    num2 = {q1[TW-1:0], 18'b0};
  end

  logic          q2_v;
  logic [KW-1:0] q2;
  logic [SW-1:0] q2_sd;

  apsp_div #(.NW(KW), .DW(31), .SIDE_W(SW)) u_div_curv (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(q1_v), .in_num(num2), .in_den(len), .in_side(q1_sd),
    .out_valid(q2_v), .out_quo(q2), .out_side(q2_sd)
  );

  // |k| * |s|
  pl_t d2_in;

  always_comb begin
    d2_in      = pl_t'(q2_sd);
    d2_in.kmag = q2;
  end

  logic           m1_v;
  logic [PPW-1:0] m1_p;
  logic [SW-1:0]  m1_sd;

  apsp_mul #(.AW(KW), .BW(PW), .SIDE_W(SW)) u_mul_ks (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(q2_v), .in_a(q2), .in_b(d2_in.sabs), .in_side(d2_in),
    .out_valid(m1_v), .out_prod(m1_p), .out_side(m1_sd)
  );

  // Scale to a half arc phase
  pl_t d3_in;

  always_comb begin
    d3_in     = pl_t'(m1_sd);
    d3_in.pz  = (m1_p[PPW-1:64] == '0);
    d3_in.h27 = m1_p[HW+18:19];
  end

  logic           m2_v;
  logic [PGW-1:0] m2_p;
  logic [SW-1:0]  m2_sd;

  apsp_mul #(.AW(PPW), .BW(HAG_W), .SIDE_W(SW)) u_mul_gain (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(m1_v), .in_a(m1_p), .in_b(HALF_ARC_GAIN), .in_side(d3_in),
    .out_valid(m2_v), .out_prod(m2_p), .out_side(m2_sd)
  );

  // Signed half arc and the small arc decision
  pl_t             d4_in;
  logic [PH_W-1:0] hmag;

  always_comb begin
    d4_in           = pl_t'(m2_sd);
    hmag            = m2_p[91:60];
    d4_in.short_arc = d4_in.pz && (m2_p[PGW-1:85] == '0);
    d4_in.hph       = (d4_in.kneg ^ d4_in.s[PW-1]) ? PH_W'(32'd0 - hmag) : hmag;
  end

  // Small arc: chord = s * (1 - h^2/6)
  logic            m3_v;
  logic [2*HW-1:0] m3_p;
  logic [SW-1:0]   m3_sd;

  apsp_mul #(.AW(HW), .BW(HW), .SIDE_W(SW)) u_mul_hsq (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(m2_v), .in_a(d4_in.h27), .in_b(d4_in.h27), .in_side(d4_in),
    .out_valid(m3_v), .out_prod(m3_p), .out_side(m3_sd)
  );

  logic                 m4_v;
  logic [UW+RCP_W-1:0]  m4_p;
  logic [SW-1:0]        m4_sd;

  apsp_mul #(.AW(UW), .BW(RCP_W), .SIDE_W(SW)) u_mul_sixth (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(m3_v), .in_a(m3_p[2*HW-1:31]), .in_b(RECIP3), .in_side(m3_sd),
    .out_valid(m4_v), .out_prod(m4_p), .out_side(m4_sd)
  );

  logic [MW-1:0] one_m;
  pl_t           d4m;

  assign one_m = Q30_ONE - MW'(m4_p[UW+RCP_W-1:24]);
  assign d4m   = pl_t'(m4_sd);

  logic             m5_v;
  logic [PW+MW-1:0] m5_p;
  logic [SW-1:0]    m5_sd;

  apsp_mul #(.AW(PW), .BW(MW), .SIDE_W(SW)) u_mul_small (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(m4_v), .in_a(d4m.sabs), .in_b(one_m), .in_side(m4_sd),
    .out_valid(m5_v), .out_prod(m5_p), .out_side(m5_sd)
  );

  pl_t d5_in;

  always_comb begin
    d5_in     = pl_t'(m5_sd);
    d5_in.csm = CW'(m5_p[PW+MW-1:30]);
  end

  // Sine of the half arc
  logic                   c2_v;
  logic signed [CS_W-1:0] c2_cos, c2_sin;
  logic [SW-1:0]          c2_sd;

  apsp_cordic #(.SIDE_W(SW)) u_cordic_half (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(m5_v), .in_phase(d5_in.hph), .in_side(d5_in),
    .out_valid(c2_v), .out_cos(c2_cos), .out_sin(c2_sin), .out_side(c2_sd)
  );

  // Chord = sin(h) * 2^19 / k
  pl_t             d6_in;
  logic [CS_W-1:0] hs_abs;
  logic [CW-1:0]   num3;

  always_comb begin
    d6_in      = pl_t'(c2_sd);
    d6_in.cneg = c2_sin[CS_W-1] ^ d6_in.kneg;
    hs_abs     = c2_sin[CS_W-1] ? CS_W'(-c2_sin) : CS_W'(c2_sin);
    num3       = {hs_abs[CS_W-2:0], 19'b0};
  end

  logic          q3_v;
  logic [CW-1:0] q3;
  logic [SW-1:0] q3_sd;

  apsp_div #(.NW(CW), .DW(KW), .SIDE_W(SW)) u_div_chord (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(c2_v), .in_num(num3), .in_den(d6_in.kmag), .in_side(d6_in),
    .out_valid(q3_v), .out_quo(q3), .out_side(q3_sd)
  );

  // Pick the chord, form the chord direction and the new heading
  pl_t             d7_in;
  logic [PH_W-1:0] nph;
  logic [PH_W-1:0] ph3;

  always_comb begin
    d7_in = pl_t'(q3_sd);
    if (d7_in.short_arc) begin
      d7_in.cmag = d7_in.csm;
      d7_in.cneg = d7_in.s[PW-1];
    end else begin
      d7_in.cmag = q3;
    end
    ph3      = d7_in.th + d7_in.hph;
    nph      = d7_in.th + {d7_in.hph[PH_W-2:0], 1'b0};
    nph      = nph + PH_W'(1 << (PS - 1));
    d7_in.nh = nph[PH_W-1:PS];
  end

  logic                   c3_v;
  logic signed [CS_W-1:0] c3_cos, c3_sin;
  logic [SW-1:0]          c3_sd;

  apsp_cordic #(.SIDE_W(SW)) u_cordic_dir (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(q3_v), .in_phase(ph3), .in_side(d7_in),
    .out_valid(c3_v), .out_cos(c3_cos), .out_sin(c3_sin), .out_side(c3_sd)
  );

  // Chord times direction cosines
  pl_t             d8_in;
  logic [CS_W-1:0] dc_abs, ds_abs;

  always_comb begin
    d8_in      = pl_t'(c3_sd);
    d8_in.xneg = d8_in.cneg ^ c3_cos[CS_W-1];
    d8_in.yneg = d8_in.cneg ^ c3_sin[CS_W-1];
    dc_abs     = c3_cos[CS_W-1] ? CS_W'(-c3_cos) : CS_W'(c3_cos);
    ds_abs     = c3_sin[CS_W-1] ? CS_W'(-c3_sin) : CS_W'(c3_sin);
  end

  logic           mx_v, my_v;
  logic [MXW-1:0] mx_p, my_p;
  logic [SW-1:0]  mx_sd;
  logic           my_sd;

  apsp_mul #(.AW(CW), .BW(CS_W-1), .SIDE_W(SW)) u_mul_dx (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(c3_v), .in_a(d8_in.cmag), .in_b(dc_abs[CS_W-2:0]), .in_side(d8_in),
    .out_valid(mx_v), .out_prod(mx_p), .out_side(mx_sd)
  );

  apsp_mul #(.AW(CW), .BW(CS_W-1), .SIDE_W(1)) u_mul_dy (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(c3_v), .in_a(d8_in.cmag), .in_b(ds_abs[CS_W-2:0]),
    .in_side(d8_in.yneg),
    .out_valid(my_v), .out_prod(my_p), .out_side(my_sd)
  );

  // Drop the Q30 fraction toward zero and apply the sign
  logic                   va_r;
  pl_t                    da_r;
  pl_t                    dmx;
  logic signed [MVW-1:0]  mvx_r, mvy_r, mvx_nxt, mvy_nxt;

  always_comb begin
    dmx     = pl_t'(mx_sd);
    mvx_nxt = dmx.xneg ? MVW'(0) - MVW'(mx_p[MXW-1:30]) : MVW'(mx_p[MXW-1:30]);
    mvy_nxt = my_sd ? MVW'(0) - MVW'(my_p[MXW-1:30]) : MVW'(my_p[MXW-1:30]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= mx_v & my_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      da_r  <= dmx;
      mvx_r <= mvx_nxt;
      mvy_r <= mvy_nxt;
    end
  end

  // Add the move and saturate
  logic signed [SUMW-1:0] sx, sy;
  logic [PW-1:0]          nx, ny;
  logic [OUT_TW-1:0]      res;

  always_comb begin
    sx = SUMW'(da_r.x) + SUMW'(mvx_r);
    sy = SUMW'(da_r.y) + SUMW'(mvy_r);
    if (sx > MAXP) begin
      nx = MAXP[PW-1:0];
    end else if (sx < MINP) begin
      nx = MINP[PW-1:0];
    end else begin
      nx = sx[PW-1:0];
    end
    if (sy > MAXP) begin
      ny = MAXP[PW-1:0];
    end else if (sy < MINP) begin
      ny = MINP[PW-1:0];
    end else begin
      ny = sy[PW-1:0];
    end
    res = OUT_TW'({da_r.nh, ny, nx});
  end

  // Output register and skid register
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [OUT_TW-1:0] out_data_r, out_data_nxt;
  logic [OUT_TW-1:0] skid_data_r, skid_data_nxt;

  assign en = ~skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (en && va_r) begin
      if (!out_valid_r || out_tready) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (out_tready) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A parked item implies one waiting at the output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds an item with no item at the output");

  // Both direction products run in lockstep
  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    mx_v == my_v)
    else $error("x and y product pipelines out of step");

  // The skid register fills only behind a stalled output
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid register filled while output was free");

  // A result that arrives while the output is stalled is parked in the skid register
  a_no_item_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && en && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("result dropped while output stalled");

endmodule
